### rtl/b32d_pkg.sv
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types, constants and helper functions of the bech32 string decoder:
// command and encoding codes, the checksum generator and the symbol table.
// ----------------------------------------------------------------------------
`default_nettype none

package b32d_pkg;

   localparam logic [6:0] MAX_LEN      = 7'd90;
   localparam logic [6:0] MIN_LEN      = 7'd8;
   localparam logic [6:0] CHECKSUM_LEN = 7'd6;
   localparam int         ADDR_W       = $clog2(int'(MAX_LEN));

   // request commands
   localparam logic [1:0] CMD_PUSH      = 2'd0;
   localparam logic [1:0] CMD_FINAL     = 2'd1;
   localparam logic [1:0] CMD_READ_DATA = 2'd2;
   localparam logic [1:0] CMD_READ_HRP  = 2'd3;

   // decode outcomes
   localparam logic [1:0] ENC_NONE    = 2'd0;
   localparam logic [1:0] ENC_BECH32  = 2'd1;
   localparam logic [1:0] ENC_BECH32M = 2'd2;

   // kinds of checksum step
   localparam logic [1:0] KIND_HI  = 2'd0;
   localparam logic [1:0] KIND_MID = 2'd1;
   localparam logic [1:0] KIND_LO  = 2'd2;
   localparam logic [1:0] KIND_DAT = 2'd3;

   localparam int          ACC_W         = 30;
   localparam logic [ACC_W-1:0] ACC_INIT  = 30'd1;
   localparam logic [ACC_W-1:0] RES_BECH32  = 30'd1;
   localparam logic [ACC_W-1:0] RES_BECH32M = 30'h2bc830a3;
   localparam logic [ACC_W-1:0] GEN0 = 30'h3b6a57b2;
   localparam logic [ACC_W-1:0] GEN1 = 30'h26508e6d;
   localparam logic [ACC_W-1:0] GEN2 = 30'h1ea119fa;
   localparam logic [ACC_W-1:0] GEN3 = 30'h3d4233dd;
   localparam logic [ACC_W-1:0] GEN4 = 30'h2a1462b3;

   localparam logic [7:0] CHAR_ONE = 8'h31;

   typedef struct packed {
      logic       clear;
      logic       valid;
      logic [1:0] kind;
   } step_type;

   typedef struct packed {
      logic [ACC_W-1:0] acc;
      logic             bad;
      logic             lower;
      logic             upper;
   } check_type;

   function automatic logic [ACC_W-1:0] poly_step(input logic [ACC_W-1:0] acc);
      logic [4:0]       top;
      logic [ACC_W-1:0] r;
      top = acc[29:25];
      r   = {acc[24:0], 5'd0};
      if (top[0]) r = r ^ GEN0;
      if (top[1]) r = r ^ GEN1;
      if (top[2]) r = r ^ GEN2;
      if (top[3]) r = r ^ GEN3;
      if (top[4]) r = r ^ GEN4;
      return r;
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return c inside {[8'h41:8'h5a]};
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return c inside {[8'h61:8'h7a]};
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return is_upper(c) ? c + 8'd32 : c;
   endfunction

   // returns {invalid, value}
   function automatic logic [5:0] sym_lookup(input logic [7:0] c);
      logic [7:0] lc;
      logic [5:0] r;
      lc = to_lower(c);
      case (lc)
         "q": r = 6'd0;   "p": r = 6'd1;   "z": r = 6'd2;   "r": r = 6'd3;
         "y": r = 6'd4;   "9": r = 6'd5;   "x": r = 6'd6;   "8": r = 6'd7;
         "g": r = 6'd8;   "f": r = 6'd9;   "2": r = 6'd10;  "t": r = 6'd11;
         "v": r = 6'd12;  "d": r = 6'd13;  "w": r = 6'd14;  "0": r = 6'd15;
         "s": r = 6'd16;  "3": r = 6'd17;  "j": r = 6'd18;  "n": r = 6'd19;
         "5": r = 6'd20;  "4": r = 6'd21;  "k": r = 6'd22;  "h": r = 6'd23;
         "c": r = 6'd24;  "e": r = 6'd25;  "6": r = 6'd26;  "m": r = 6'd27;
         "u": r = 6'd28;  "a": r = 6'd29;  "7": r = 6'd30;  "l": r = 6'd31;
         default: r = 6'd32;
      endcase
      if (c[7]) r = 6'd32;
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/b32d_polymod.sv
// ----------------------------------------------------------------------------
// b32d_polymod
// Checksum accumulator: one polymod step per valid step request, plus the
// character range, symbol and letter case checks on the hrp-high and data steps.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_polymod (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire b32d_pkg::step_type   step,
   input  wire logic [7:0]           byte_in,
   output b32d_pkg::check_type       status
);
   import b32d_pkg::*;

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             bad_ff, bad_in;
   logic             lower_ff, lower_in;
   logic             upper_ff, upper_in;
   logic [7:0]       lc;
   logic [5:0]       sym;
   logic [ACC_W-1:0] stepped;

   always_comb begin
      lc       = to_lower(byte_in);
      sym      = sym_lookup(byte_in);
      stepped  = poly_step(acc_ff);
      acc_in   = acc_ff;
      bad_in   = bad_ff;
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (step.clear) begin
         acc_in   = ACC_INIT;
         bad_in   = 1'b0;
         lower_in = 1'b0;
         upper_in = 1'b0;
      end else if (step.valid) begin
         case (step.kind)
            KIND_HI: begin
               if (!(byte_in inside {[8'd33:8'd126]})) bad_in = 1'b1;
               if (is_lower(byte_in)) lower_in = 1'b1;
               if (is_upper(byte_in)) upper_in = 1'b1;
               acc_in = stepped ^ {27'd0, lc[7:5]};
            end
            KIND_MID: begin
               acc_in = stepped;
            end
            KIND_LO: begin
               acc_in = stepped ^ {25'd0, byte_in[4:0]};
            end
            KIND_DAT: begin
               if (sym[5]) bad_in = 1'b1;
               if (is_lower(byte_in)) lower_in = 1'b1;
               if (is_upper(byte_in)) upper_in = 1'b1;
               acc_in = stepped ^ {25'd0, sym[4:0]};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= ACC_INIT;
         bad_ff   <= 1'b0;
         lower_ff <= 1'b0;
         upper_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         bad_ff   <= bad_in;
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   assign status.acc   = acc_ff;
   assign status.bad   = bad_ff;
   assign status.lower = lower_ff;
   assign status.upper = upper_ff;

endmodule

`default_nettype wire

### rtl/bech32_string_decoder.sv
// ----------------------------------------------------------------------------
// bech32_string_decoder
// Loads a bech32 / bech32m string byte by byte into a 90-byte store, checks
// and decodes it on the final byte and answers hrp and data reads.
//
//   channel   dir   ports                                         role
//   req       in    req_valid req_stall req_command req_char_byte  command
//                   req_read_index
//   rsp       out   rsp_valid rsp_stall rsp_encoding rsp_hrp_length one result
//                   rsp_payload_length rsp_read_value              per request
//
// A read does one store read, then the lookup. A final push is first checked
// for length and separator; if that passes, the checksum walks the store twice
// over the hrp and once over the data (data with its checksum) through
// the one read port.
// Reset clears control and outcome registers; the byte store is not cleared.
// Requests are stalled while a command is in progress or the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bech32_string_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_command,
   input  wire logic [7:0] req_char_byte,
   input  wire logic [6:0] req_read_index,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_encoding,
   output logic [6:0]      rsp_hrp_length,
   output logic [6:0]      rsp_payload_length,
   output logic [6:0]      rsp_read_value
);
   import b32d_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [6:0]       count_ff, count_in;
   logic [6:0]       sep_ff, sep_in;
   logic             found_ff, found_in;
   logic             overflow_ff, overflow_in;
   logic             start_new_ff, start_new_in;
   logic [1:0]       enc_ff, enc_in;
   logic [6:0]       hrp_len_ff, hrp_len_in;
   logic [6:0]       pay_len_ff, pay_len_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_enc_ff, rsp_enc_in;
   logic [6:0]       rsp_hrp_ff, rsp_hrp_in;
   logic [6:0]       rsp_pay_ff, rsp_pay_in;
   logic [6:0]       rsp_val_ff, rsp_val_in;
   logic [1:0]       phase_ff, phase_in;
   logic [6:0]       idx_ff, idx_in;
   step_type         tag_ff, tag_in;
   logic             rd_hrp_ff, rd_hrp_in;
   logic             rd_ok_ff, rd_ok_in;

   logic [7:0]       mem [int'(MAX_LEN)];
   logic [7:0]       rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic             mem_we;
   logic [ADDR_W-1:0] wr_addr;

   check_type        status;
   logic             req_accept;
   logic             rsp_take;
   logic [6:0]       eff_count;
   logic             room;
   logic [7:0]       data_pos;
   logic             data_ok;
   logic             hrp_ok;
   logic [6:0]       tail_len;
   logic             precheck_fail;
   logic             good;
   logic [1:0]       enc_res;
   logic [7:0]       rd_lc;
   logic [5:0]       rd_sym;

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;

   assign eff_count = start_new_ff ? 7'd0 : count_ff;
   assign room      = eff_count < MAX_LEN;
   assign mem_we    = req_accept && room &&
                      ((req_command == CMD_PUSH) || (req_command == CMD_FINAL));
   assign wr_addr   = eff_count[ADDR_W-1:0];

   assign data_pos  = {1'b0, hrp_len_ff} + 8'd1 + {1'b0, req_read_index};
   assign data_ok   = (req_read_index < pay_len_ff) && (data_pos < {1'b0, count_ff});
   assign hrp_ok    = (req_read_index < hrp_len_ff) && (req_read_index < count_ff);

   assign tail_len      = count_ff - 7'd1 - sep_ff;
   assign precheck_fail = overflow_ff || (count_ff < MIN_LEN) || !found_ff ||
                          (sep_ff == 7'd0) || (tail_len < CHECKSUM_LEN);

   // final verdict from the accumulated checksum and the character and case flags
   always_comb begin
      if (status.acc == RES_BECH32) begin
         enc_res = ENC_BECH32;
      end else if (status.acc == RES_BECH32M) begin
         enc_res = ENC_BECH32M;
      end else begin
         enc_res = ENC_NONE;
      end
      good = !status.bad && !(status.lower && status.upper) && (enc_res != ENC_NONE);
   end

   always_comb begin
      if (state_ff == ST_WALK) begin
         rd_addr = idx_ff[ADDR_W-1:0];
      end else if (req_command == CMD_READ_DATA && data_ok) begin
         rd_addr = data_pos[ADDR_W-1:0];
      end else if (req_command == CMD_READ_HRP && hrp_ok) begin
         rd_addr = req_read_index[ADDR_W-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   assign rd_lc  = to_lower(rd_data_ff);
   assign rd_sym = sym_lookup(rd_data_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sep_in       = sep_ff;
      found_in     = found_ff;
      overflow_in  = overflow_ff;
      start_new_in = start_new_ff;
      enc_in       = enc_ff;
      hrp_len_in   = hrp_len_ff;
      pay_len_in   = pay_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_enc_in   = rsp_enc_ff;
      rsp_hrp_in   = rsp_hrp_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_val_in   = rsp_val_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      tag_in       = '0;
      rd_hrp_in    = rd_hrp_ff;
      rd_ok_in     = rd_ok_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_command == CMD_PUSH || req_command == CMD_FINAL) begin
                  if (start_new_ff) begin
                     start_new_in = 1'b0;
                     count_in     = 7'd0;
                     overflow_in  = 1'b0;
                     found_in     = 1'b0;
                     enc_in       = ENC_NONE;
                     hrp_len_in   = 7'd0;
                     pay_len_in   = 7'd0;
                  end
                  if (room) begin
                     count_in = eff_count + 7'd1;
                     if (req_char_byte == CHAR_ONE) begin
                        sep_in   = eff_count;
                        found_in = 1'b1;
                     end
                  end else begin
                     overflow_in = 1'b1;
                  end
                  if (req_command == CMD_PUSH) begin
                     rsp_valid_in = 1'b1;
                     rsp_enc_in   = enc_in;
                     rsp_hrp_in   = hrp_len_in;
                     rsp_pay_in   = pay_len_in;
                     rsp_val_in   = 7'd0;
                  end else begin
                     start_new_in = 1'b1;
                     tag_in.clear = 1'b1;
                     state_in     = ST_CHECK;
                  end
               end else begin
                  rd_hrp_in = (req_command == CMD_READ_HRP);
                  rd_ok_in  = (req_command == CMD_READ_HRP) ? hrp_ok : data_ok;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_enc_in   = enc_ff;
            rsp_hrp_in   = hrp_len_ff;
            rsp_pay_in   = pay_len_ff;
            if (!rd_ok_ff) begin
               rsp_val_in = 7'd0;
            end else if (rd_hrp_ff) begin
               rsp_val_in = rd_lc[6:0];
            end else begin
               rsp_val_in = rd_sym[5] ? 7'd0 : {2'd0, rd_sym[4:0]};
            end
            state_in = ST_IDLE;
         end
         ST_CHECK: begin
            if (precheck_fail) begin
               enc_in       = ENC_NONE;
               hrp_len_in   = 7'd0;
               pay_len_in   = 7'd0;
               rsp_valid_in = 1'b1;
               rsp_enc_in   = ENC_NONE;
               rsp_hrp_in   = 7'd0;
               rsp_pay_in   = 7'd0;
               rsp_val_in   = 7'd0;
               state_in     = ST_IDLE;
            end else begin
               phase_in = KIND_HI;
               idx_in   = 7'd0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // issue one store read per cycle; the step follows with the data
            tag_in.valid = 1'b1;
            tag_in.kind  = phase_ff;
            case (phase_ff)
               KIND_HI: begin
                  if (idx_ff == sep_ff - 7'd1) begin
                     phase_in = KIND_MID;
                  end else begin
                     idx_in = idx_ff + 7'd1;
                  end
               end
               KIND_MID: begin
                  phase_in = KIND_LO;
                  idx_in   = 7'd0;
               end
               KIND_LO: begin
                  if (idx_ff == sep_ff - 7'd1) begin
                     phase_in = KIND_DAT;
                     idx_in   = sep_ff + 7'd1;
                  end else begin
                     idx_in = idx_ff + 7'd1;
                  end
               end
               KIND_DAT: begin
                  if (idx_ff == count_ff - 7'd1) begin
                     state_in = ST_DRAIN;
                  end else begin
                     idx_in = idx_ff + 7'd1;
                  end
               end
               default: begin
                  state_in = ST_DRAIN;
               end
            endcase
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            enc_in       = good ? enc_res : ENC_NONE;
            hrp_len_in   = good ? sep_ff : 7'd0;
            pay_len_in   = good ? (tail_len - CHECKSUM_LEN) : 7'd0;
            rsp_valid_in = 1'b1;
            rsp_enc_in   = enc_in;
            rsp_hrp_in   = hrp_len_in;
            rsp_pay_in   = pay_len_in;
            rsp_val_in   = 7'd0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_char_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 7'd0;
         found_ff     <= 1'b0;
         overflow_ff  <= 1'b0;
         start_new_ff <= 1'b1;
         enc_ff       <= ENC_NONE;
         hrp_len_ff   <= 7'd0;
         pay_len_ff   <= 7'd0;
         rsp_valid_ff <= 1'b0;
         tag_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         overflow_ff  <= overflow_in;
         start_new_ff <= start_new_in;
         enc_ff       <= enc_in;
         hrp_len_ff   <= hrp_len_in;
         pay_len_ff   <= pay_len_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_ff       <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      sep_ff     <= sep_in;
      rsp_enc_ff <= rsp_enc_in;
      rsp_hrp_ff <= rsp_hrp_in;
      rsp_pay_ff <= rsp_pay_in;
      rsp_val_ff <= rsp_val_in;
      phase_ff   <= phase_in;
      idx_ff     <= idx_in;
      rd_hrp_ff  <= rd_hrp_in;
      rd_ok_ff   <= rd_ok_in;
   end

   b32d_polymod u_polymod (
      .clock   (clock),
      .reset   (reset),
      .step    (tag_ff),
      .byte_in (rd_data_ff),
      .status  (status)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_encoding       = rsp_enc_ff;
   assign rsp_hrp_length     = rsp_hrp_ff;
   assign rsp_payload_length = rsp_pay_ff;
   assign rsp_read_value     = rsp_val_ff;

`ifndef ASSERT_OFF
   a_read_goes_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_command == CMD_READ_DATA || req_command == CMD_READ_HRP)
      |=> state_ff == ST_READ)
      else $error("read request did not enter the lookup state");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_LEN)
      else $error("byte count beyond store depth");

   a_step_only_in_walk: assert property (@(posedge clock) disable iff (reset)
      tag_ff.valid |-> (state_ff == ST_WALK || state_ff == ST_DRAIN))
      else $error("checksum step outside the walk");

   a_lengths_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_encoding != ENC_NONE
      |-> rsp_hrp_length != 7'd0 &&
          ({1'b0, rsp_hrp_length} + {1'b0, rsp_payload_length} + 8'd7) <= {1'b0, MAX_LEN})
      else $error("decoded lengths do not fit the string");
`endif

endmodule

`default_nettype wire
